// ----- rtl/mi4_pkg.sv -----
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared types, widths and index helpers for the 4x4 matrix inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

    localparam int ELEM_W = 16;   // Q8.8 input element
    localparam int ADJ_W  = 48;   // exact 3x3 cofactor
    localparam int PROD_W = 64;   // shared multiplier result
    localparam int DET_W  = 67;   // exact Q35.32 determinant
    localparam int INV_W  = 32;   // Q16.16 inverse element
    localparam int DOUT_W = 64;   // saturated determinant output
    localparam int NUM_W  = ADJ_W + 24;     // scaled numerator
    localparam int DSH_W  = DET_W + 31;     // shifted divisor

    // sequencer states
    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_COF  = 5'b00010,
        S_DET  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // divider request and response
    typedef struct packed {
        logic                    start;
        logic signed [ADJ_W-1:0] adj;
        logic signed [DET_W-1:0] det;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [INV_W-1:0] quot;
    } t_div_rsp;

    // column picked for minor row k by permutation p of three
    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
        logic [5:0] cols;
        begin
            unique case (p)
                3'd0:    cols = {2'd2, 2'd1, 2'd0};
                3'd1:    cols = {2'd0, 2'd2, 2'd1};
                3'd2:    cols = {2'd1, 2'd0, 2'd2};
                3'd3:    cols = {2'd1, 2'd2, 2'd0};
                3'd4:    cols = {2'd2, 2'd0, 2'd1};
                3'd5:    cols = {2'd0, 2'd1, 2'd2};
                default: cols = {2'd2, 2'd1, 2'd0};
            endcase
            unique case (k)
                2'd0:    return cols[1:0];
                2'd1:    return cols[3:2];
                default: return cols[5:4];
            endcase
        end
    endfunction

    // odd permutations carry a minus sign
    function automatic logic perm_neg(input logic [2:0] p);
        return (p >= 3'd3);
    endfunction

    // minor index k mapped to a full index, skipping index s
    function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] s);
        return (k < s) ? k : k + 2'd1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/matrix_inverse_4x4_core.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_core
// 4x4 matrix inverse by adjugate: loads 16 Q8.8 elements, forms the cofactors
// and determinant on one shared multiplier, then divides on a serial divider.
// ----------------------------------------------------------------------------
// Loading takes one element a cycle while the sequencer is in its load state.
// Each cofactor sums six permutation terms on the shared multiplier; the
// determinant follows. Each result then goes to the one-bit-a-cycle divider,
// which is skipped when singular; no input is taken until all are sent.
// Synchronous active-low reset returns the sequencer to loading at element 0.
`default_nettype none

module matrix_inverse_4x4_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [mi4_pkg::ELEM_W-1:0]   i_element,
    output logic                                     o_stall,
    output logic                                     o_valid,
    output logic signed [mi4_pkg::INV_W-1:0]         o_inverse_element,
    output logic signed [mi4_pkg::DOUT_W-1:0]        o_determinant,
    output logic                                     o_singular,
    output logic                                     o_last,
    input  wire logic                                i_stall
);
    import mi4_pkg::*;

    // control registers
    t_state       r_state,    n_state;
    logic [3:0]   r_load_cnt, n_load_cnt;
    logic [3:0]   r_cof,      n_cof;
    logic [2:0]   r_perm,     n_perm;
    logic [1:0]   r_ph,       n_ph;
    logic [3:0]   r_k,        n_k;
    logic         r_div_run,  n_div_run;
    logic         r_ovalid,   n_ovalid;

    // payload registers
    logic signed [ELEM_W-1:0] r_p,       n_p;
    logic signed [ADJ_W-1:0]  r_acc,     n_acc;
    logic signed [DET_W-1:0]  r_det,     n_det;
    logic signed [INV_W-1:0]  r_inv,     n_inv;
    logic signed [DOUT_W-1:0] r_det_out, n_det_out;
    logic                     r_sing,    n_sing;
    logic                     r_last,    n_last;
    logic signed [ELEM_W-1:0] r_mat [16];
    logic signed [ADJ_W-1:0]  r_adj [16];

    logic                     in_xfer;
    logic                     adj_we;
    logic [1:0]               cof_i, cof_j;
    logic [1:0]               row_sel, col_sel;
    logic signed [ELEM_W-1:0] elem_rd;
    logic [3:0]               adj_idx;
    logic signed [ADJ_W-1:0]  adj_rd;
    logic signed [ADJ_W-1:0]  mul_a;
    logic signed [PROD_W-1:0] prod;
    logic signed [ADJ_W-1:0]  term;
    logic                     term_neg;
    logic signed [ADJ_W-1:0]  acc_next;
    logic                     det_zero;
    logic                     det_fits;
    logic signed [DOUT_W-1:0] det_sat;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    assign in_xfer = i_valid && !o_stall;
    assign o_stall = (r_state != S_LOAD);

    // element and cofactor read selection
    assign cof_i   = r_cof[3:2];
    assign cof_j   = r_cof[1:0];
    assign row_sel = (r_state == S_DET) ? 2'd0 : skip_idx(r_ph, cof_j);
    assign col_sel = (r_state == S_DET) ? r_cof[1:0]
                                        : skip_idx(perm_col(r_perm, r_ph), cof_i);
    assign elem_rd = r_mat[{row_sel, col_sel}];
    assign adj_idx = (r_state == S_DET) ? {r_cof[1:0], 2'b00} : r_k;
    assign adj_rd  = r_adj[adj_idx];

    // shared multiplier operand select
    always_comb begin
        priority if (r_state == S_COF && r_ph == 2'd1) begin
            mul_a = {{(ADJ_W - ELEM_W){r_p[ELEM_W-1]}}, r_p};
        end else if (r_state == S_COF && r_ph == 2'd2) begin
            mul_a = prod[ADJ_W-1:0];
        end else begin
            mul_a = adj_rd;
        end
    end

    mi4_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (elem_rd),
        .o_prod (prod)
    );

    // cofactor accumulate with permutation and checkerboard sign
    assign term     = prod[ADJ_W-1:0];
    assign term_neg = perm_neg(r_perm) ^ cof_i[0] ^ cof_j[0];
    assign acc_next = term_neg ? r_acc - term : r_acc + term;

    // determinant status
    assign det_zero = (r_det == '0);
    assign det_fits = (&r_det[DET_W-1:DOUT_W-1]) || !(|r_det[DET_W-1:DOUT_W-1]);
    assign det_sat  = det_fits ? r_det[DOUT_W-1:0]
                    : (r_det[DET_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);

    // divider
    assign div_req.start = (r_state == S_DIV) && !det_zero && !r_div_run;
    assign div_req.adj   = adj_rd;
    assign div_req.det   = r_det;

    mi4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_cof      = r_cof;
        n_perm     = r_perm;
        n_ph       = r_ph;
        n_k        = r_k;
        n_div_run  = r_div_run;
        n_ovalid   = r_ovalid;
        n_p        = r_p;
        n_acc      = r_acc;
        n_det      = r_det;
        n_inv      = r_inv;
        n_det_out  = r_det_out;
        n_sing     = r_sing;
        n_last     = r_last;
        adj_we     = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    n_load_cnt = r_load_cnt + 4'd1;
                    if (r_load_cnt == 4'd15) begin
                        n_state = S_COF;
                        n_cof   = '0;
                        n_perm  = '0;
                        n_ph    = '0;
                        n_acc   = '0;
                    end
                end
            end
            S_COF: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd0) begin
                    n_p = elem_rd;
                end
                if (r_ph == 2'd3) begin
                    n_acc = acc_next;
                    if (r_perm == 3'd5) begin
                        adj_we = 1'b1;
                        n_acc  = '0;
                        n_perm = '0;
                        n_cof  = r_cof + 4'd1;
                        if (r_cof == 4'd15) begin
                            n_state = S_DET;
                            n_det   = '0;
                        end
                    end else begin
                        n_perm = r_perm + 3'd1;
                    end
                end
            end
            S_DET: begin
                if (r_ph == 2'd1) begin
                    n_ph  = 2'd0;
                    n_det = r_det + {{(DET_W - PROD_W){prod[PROD_W-1]}}, prod};
                    n_cof = r_cof + 4'd1;
                    if (r_cof == 4'd3) begin
                        n_state = S_DIV;
                        n_cof   = '0;
                        n_k     = '0;
                    end
                end else begin
                    n_ph = 2'd1;
                end
            end
            S_DIV: begin
                if (det_zero || (r_div_run && div_rsp.done)) begin
                    n_state   = S_OUT;
                    n_div_run = 1'b0;
                    n_ovalid  = 1'b1;
                    n_inv     = det_zero ? '0 : div_rsp.quot;
                    n_det_out = det_sat;
                    n_sing    = det_zero;
                    n_last    = (r_k == 4'd15);
                end else if (!r_div_run) begin
                    n_div_run = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    n_k      = r_k + 4'd1;
                    n_state  = (r_k == 4'd15) ? S_LOAD : S_DIV;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_cof      <= '0;
            r_perm     <= '0;
            r_ph       <= '0;
            r_k        <= '0;
            r_div_run  <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_cof      <= n_cof;
            r_perm     <= n_perm;
            r_ph       <= n_ph;
            r_k        <= n_k;
            r_div_run  <= n_div_run;
            r_ovalid   <= n_ovalid;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_acc     <= n_acc;
        r_det     <= n_det;
        r_inv     <= n_inv;
        r_det_out <= n_det_out;
        r_sing    <= n_sing;
        r_last    <= n_last;
    end

    // matrix and cofactor stores
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mat[r_load_cnt] <= i_element;
        end
        if (adj_we) begin
            r_adj[{cof_i, cof_j}] <= acc_next;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_inverse_element = r_inv;
    assign o_determinant     = r_det_out;
    assign o_singular        = r_sing;
    assign o_last            = r_last;

    // checks
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_inverse_element == '0)
        else $error("singular result with nonzero element");

    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT)
        else $error("result shown outside output state");

    a_last_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> r_k == 4'd15)
        else $error("last flag on wrong element");

    a_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_run |-> r_state == S_DIV)
        else $error("divider running outside divide state");

endmodule

`default_nettype wire

// ----- rtl/mi4_mul.sv -----
// ----------------------------------------------------------------------------
// mi4_mul
// Shared signed 48x16 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [mi4_pkg::ADJ_W-1:0]    i_a,
    input  wire logic signed [mi4_pkg::ELEM_W-1:0]   i_b,
    output logic signed [mi4_pkg::PROD_W-1:0]        o_prod
);
    import mi4_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a * i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- rtl/mi4_div.sv -----
// ----------------------------------------------------------------------------
// mi4_div
// Restoring divider: floor(|adj| * 2^24 / |det|), one quotient bit a cycle,
// then sign and saturation to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mi4_pkg::t_div_req i_req,
    output mi4_pkg::t_div_rsp      o_rsp
);
    import mi4_pkg::*;

    logic [ADJ_W-1:0]   a_mag;
    logic [DET_W-1:0]   d_mag;
    logic [NUM_W-1:0]   num;
    logic               sat_now;
    logic               ge;

    logic [NUM_W-1:0]   r_rem;
    logic [DSH_W-1:0]   r_dsh;
    logic [INV_W-1:0]   r_q;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic               r_sat;

    // operand magnitudes and the overflow check
    assign a_mag   = i_req.adj[ADJ_W-1] ? ADJ_W'(-i_req.adj) : ADJ_W'(i_req.adj);
    assign d_mag   = i_req.det[DET_W-1] ? DET_W'(-i_req.det) : DET_W'(i_req.det);
    assign num     = {a_mag, 24'd0};
    assign sat_now = {{(DET_W + 32 - NUM_W){1'b0}}, num} >= {d_mag, 32'd0};

    // trial subtract
    assign ge = {{(DSH_W - NUM_W){1'b0}}, r_rem} >= r_dsh;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= num;
            r_dsh <= {d_mag, 31'd0};
            r_q   <= '0;
            r_neg <= i_req.adj[ADJ_W-1] ^ i_req.det[DET_W-1];
            r_sat <= sat_now;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh[NUM_W-1:0];
            end
            r_q   <= {r_q[INV_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    // sign and saturation
    always_comb begin
        o_rsp.done = r_done;
        if (r_sat) begin
            o_rsp.quot = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (r_neg) begin
            o_rsp.quot = (r_q > 32'h8000_0000) ? 32'h8000_0000 : INV_W'(-r_q);
        end else begin
            o_rsp.quot = r_q[INV_W-1] ? 32'h7FFF_FFFF : r_q;
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 matrix inverse core: streams matrices in,
// predicts the adjugate inverse exactly and compares every result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

// expected results of the inverse, held in transfer order
class inverse_scoreboard;
    logic [15:0] elems [16];
    int unsigned load_idx;
    logic [31:0] inv_q [$];
    logic [63:0] det_q [$];
    logic        sing_q [$];
    logic        last_q [$];
    int unsigned errors;

    function void reset_state();
        load_idx = 0;
        errors   = 0;
    endfunction

    function logic signed [127:0] el(int r, int c);
        return {{112{elems[r*4+c][15]}}, elems[r*4+c]};
    endfunction

    // 3x3 minor with row sr and column sc removed
    function logic signed [127:0] minor_det(int sr, int sc);
        int rs [3];
        int cs [3];
        int k;
        k = 0;
        for (int i = 0; i < 4; i++) if (i != sr) begin rs[k] = i; k++; end
        k = 0;
        for (int i = 0; i < 4; i++) if (i != sc) begin cs[k] = i; k++; end
        return el(rs[0], cs[0]) * (el(rs[1], cs[1]) * el(rs[2], cs[2])
                                 - el(rs[2], cs[1]) * el(rs[1], cs[2]))
             - el(rs[0], cs[1]) * (el(rs[1], cs[0]) * el(rs[2], cs[2])
                                 - el(rs[2], cs[0]) * el(rs[1], cs[2]))
             + el(rs[0], cs[2]) * (el(rs[1], cs[0]) * el(rs[2], cs[1])
                                 - el(rs[2], cs[0]) * el(rs[1], cs[1]));
    endfunction

    // exact quotient, truncated toward zero, saturated to q16.16
    function logic [31:0] quotient(logic signed [127:0] adj, logic signed [127:0] det);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        neg = (adj < 0) != (det < 0);
        n = ((adj < 0) ? -adj : adj) << 24;
        d = (det < 0) ? -det : det;
        q = n / d;
        if (neg) return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function void note_element(logic [15:0] value);
        logic signed [127:0] adj [4][4];
        logic signed [127:0] det;
        logic [63:0]         det_out;
        elems[load_idx] = value;
        load_idx = (load_idx + 1) % 16;
        if (load_idx != 0) return;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                adj[i][j] = minor_det(j, i);
                if ((i + j) % 2 == 1) adj[i][j] = -adj[i][j];
            end
        det = 0;
        for (int j = 0; j < 4; j++) det += el(0, j) * adj[j][0];
        if (det > 128'sh7FFF_FFFF_FFFF_FFFF) det_out = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (det < -128'sh8000_0000_0000_0000) det_out = 64'h8000_0000_0000_0000;
        else det_out = det[63:0];
        for (int k = 0; k < 16; k++) begin
            inv_q.push_back((det == 0) ? 32'd0 : quotient(adj[k/4][k%4], det));
            det_q.push_back(det_out);
            sing_q.push_back(det == 0);
            last_q.push_back(k == 15);
        end
    endfunction

    function void check_result(logic [31:0] inv, logic [63:0] det, logic sing, logic lst);
        logic [31:0] e_inv;
        logic [63:0] e_det;
        logic        e_sing;
        logic        e_last;
        if (inv_q.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
        end
        e_inv = inv_q.pop_front();
        e_det = det_q.pop_front();
        e_sing = sing_q.pop_front();
        e_last = last_q.pop_front();
        if (inv !== e_inv) begin
            $error("inverse_element expected %h actual %h", e_inv, inv); errors++;
        end
        if (det !== e_det) begin
            $error("determinant expected %h actual %h", e_det, det); errors++;
        end
        if (sing !== e_sing) begin
            $error("singular expected %b actual %b", e_sing, sing); errors++;
        end
        if (lst !== e_last) begin
            $error("last expected %b actual %b", e_last, lst); errors++;
        end
    endfunction

    function int unsigned pending();
        return inv_q.size();
    endfunction
endclass

module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic signed [mi4_pkg::ELEM_W-1:0] i_element = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic signed [mi4_pkg::INV_W-1:0]  o_inverse_element;
    logic signed [mi4_pkg::DOUT_W-1:0] o_determinant;
    logic        o_singular;
    logic        o_last;

    inverse_scoreboard sb = new();
    logic        sink_quiet = 1'b0;   // no random stalls
    logic        sink_hold  = 1'b0;   // long hold-off requested
    int          src_idle_pct = 20;

    matrix_inverse_4x4_core DUT (.*);

    always #1 i_clk = ~i_clk;

    // accepted transfers on both sides
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_element(i_element);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_inverse_element, o_determinant, o_singular, o_last);
    end

    // receiver stall: random, quiet or held off
    always @(negedge i_clk) begin
        if (sink_hold) i_stall <= 1'b1;
        else if (sink_quiet) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 20);
    end

    // offer one element and wait for its transfer; valid is left to the caller
    task automatic send_element(logic [15:0] value);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_element <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_matrix(logic [15:0] m [16]);
        for (int i = 0; i < 16; i++) send_element(m[i]);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    logic [15:0] mat [16];

    // random element: mostly small, sometimes extreme
    function automatic logic [15:0] rand_elem(int kind);
        case (kind)
            0: return 16'($urandom_range(0, 1023) - 512);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int kind;
        sb.reset_state();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity scaled to 1.0
        for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 16'h0100 : 16'h0000;
        send_matrix(mat);
        // all zero: singular
        for (int i = 0; i < 16; i++) mat[i] = 16'h0000;
        send_matrix(mat);
        // tiny diagonal: large quotient, with negative entry
        for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 16'h0001 : 16'h0000;
        mat[5] = 16'hFFFF;
        send_matrix(mat);
        // large extremes: full-scale diagonal and off-diagonal entries
        for (int i = 0; i < 16; i++)
            mat[i] = (i % 5 == 0) ? 16'h8000 : ((i % 2) ? 16'h7FFF : 16'h0000);
        send_matrix(mat);
        wait_drained();

        // long hold-off while the sender keeps offering
        sink_hold <= 1'b1;
        fork
            begin
                for (int i = 0; i < 32; i++) send_element(rand_elem(0));
                i_valid <= 1'b0;
            end
            begin
                repeat (3000) @(negedge i_clk);
                sink_hold <= 1'b0;
            end
        join
        wait_drained();

        // random matrices, a quiet stretch in the middle
        for (int m = 0; m < 3; m++) begin
            if (m == 1) begin sink_quiet <= 1'b1; src_idle_pct = 0; end
            if (m == 2) begin sink_quiet <= 1'b0; src_idle_pct = 20; end
            kind = (m == 2) ? 2 : (m % 2);
            for (int i = 0; i < 16; i++) mat[i] = rand_elem(kind == 1 ? $urandom_range(0, 2) : kind);
            if (m == 1) for (int i = 0; i < 4; i++) mat[4+i] = mat[i];
            send_matrix(mat);
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/mi4_pkg.sv
rtl/mi4_mul.sv
rtl/mi4_div.sv
rtl/matrix_inverse_4x4_core.sv
bench/tb_top.sv
